@@ src/assert_macros.svh @@
// assertion macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ src/spwr_pkg.sv @@
// types and constants of the sorted policy table warp resolver
`timescale 1ns / 1ps

package spwr_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam logic [4:0] LIMIT_RESET = 5'd16;

  localparam logic [2:0] REQ_INSERT   = 3'd0;
  localparam logic [2:0] REQ_FIND_ID  = 3'd1;
  localparam logic [2:0] REQ_FIND_DOM = 3'd2;
  localparam logic [2:0] REQ_RES_ID   = 3'd3;
  localparam logic [2:0] REQ_RES_DOM  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] policy_key;
    logic [63:0] domain_key;
    logic [31:0] warp_floor;
    logic [31:0] warp_ceiling;
    logic [31:0] interest_limit;
    logic [31:0] requested_rate;
    logic        interest_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] found_policy;
    logic [63:0] found_domain;
    logic [31:0] found_floor;
    logic [31:0] found_ceiling;
    logic [31:0] found_cap;
    logic [31:0] resolved_rate;
    logic [4:0]  entries_used;
  } rsp_t;

  typedef struct packed {
    logic [63:0] id;
    logic [63:0] domain;
    logic [31:0] floor_val;
    logic [31:0] ceiling_val;
    logic [31:0] cap_val;
  } entry_t;

endpackage

@@ src/sorted_policy_table_warp_resolver_core.sv @@
// sorted policy table with lookup by id or domain and warp clamping
//
// usage: one request beat on req (valid/stall) yields one response beat on
// rsp (valid/stall). the table limit is written on cfg (valid/ready, always
// ready) by the user only while no request is in flight, which the block does
// not enforce; values above the depth saturate. the table lives in one memory
// with one read and one write port and a registered read; every step of a
// request walks it one entry at a time. a find reads and compares entries in
// order until a match, a larger id (by id only) or the end of the count; a
// resolve hit then limits the window and clamps the rate, a resolve miss
// returns the requested rate, or 1 if it is zero. an insert searches the same
// way, then moves the entries above its place up one by one and writes the new
// entry; a duplicate ends after the search. a full table or an unknown type
// goes straight to the response. req_stall is high from the accept until the
// response is loaded, so one request is handled at a time and the next beat
// is taken only once the block is back in idle; the response sits in an output
// register and a stalled rsp holds it while the next request is already taken.
// reset empties the table (entries above the count are never used) and sets the limit to 16.
`timescale 1ns / 1ps

module sorted_policy_table_warp_resolver_core #(
  parameter int TABLE_DEPTH = spwr_pkg::TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  spwr_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output spwr_pkg::rsp_t  rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [4:0]      cfg_data
);
  import spwr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int UW = (CW > 5) ? CW : 5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_GRANT_LIM,
    S_GRANT_OUT,
    S_DONE
  } state_t;

  state_t        state;
  req_t          cur;
  logic [CW-1:0] cnt;
  logic [4:0]    limit;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [1:0]    res_status;
  logic          res_hit;
  entry_t        res_entry;
  logic [31:0]   res_rate;
  logic [31:0]   lo_r;
  logic [31:0]   hi_r;

  entry_t        mem [TABLE_DEPTH];
  entry_t        rd_data;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  logic [CW-1:0] idx_m1;
  logic [UW-1:0] usable;
  logic          full;
  logic          by_domain;
  logic          is_insert;
  logic          is_resolve;
  logic          match;
  logic          past;
  logic [31:0]   miss_rate;
  logic [31:0]   lo_eff;
  logic [31:0]   hi_eff;
  logic [31:0]   cap_eff;
  logic [31:0]   req_eff;

  function automatic logic [31:0] bnd(input logic [31:0] v, input logic [31:0] lo,
                                      input logic [31:0] hi);
    logic [31:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign idx_m1 = idx - CW'(1);
  assign usable = (UW'(limit) < UW'(TABLE_DEPTH)) ? UW'(limit) : UW'(TABLE_DEPTH);
  assign full   = (UW'(cnt) >= usable);

  assign by_domain  = (cur.req_type == REQ_FIND_DOM) || (cur.req_type == REQ_RES_DOM);
  assign is_insert  = (cur.req_type == REQ_INSERT);
  assign is_resolve = (cur.req_type == REQ_RES_ID) || (cur.req_type == REQ_RES_DOM);
  assign match      = by_domain ? (rd_data.domain == cur.domain_key)
                                : (rd_data.id == cur.policy_key);
  assign past       = !by_domain && (rd_data.id > cur.policy_key);
  assign miss_rate  = (cur.requested_rate != 32'd0) ? cur.requested_rate : 32'd1;

  // a zero floor becomes 1, a zero ceiling the floor and a zero cap the ceiling
  assign lo_eff  = (res_entry.floor_val != 32'd0) ? res_entry.floor_val : 32'd1;
  assign hi_eff  = (res_entry.ceiling_val != 32'd0) ? res_entry.ceiling_val : lo_eff;
  assign cap_eff = (res_entry.cap_val != 32'd0) ? res_entry.cap_val : hi_eff;
  assign req_eff = miss_rate;

  // memory addressing follows the sequencer state
  always_comb begin
    rd_addr = (state == S_SHIFT_RD) ? idx_m1[AW-1:0] : idx[AW-1:0];
    wr_en   = (state == S_SHIFT_WR) || (state == S_INS_WR);
    wr_addr = (state == S_SHIFT_WR) ? idx[AW-1:0] : pos[AW-1:0];
    if (state == S_SHIFT_WR) begin
      wr_data = rd_data;
    end else begin
      wr_data.id          = cur.policy_key;
      wr_data.domain      = cur.domain_key;
      wr_data.floor_val   = cur.warp_floor;
      wr_data.ceiling_val = cur.warp_ceiling;
      wr_data.cap_val     = cur.interest_limit;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      limit     <= LIMIT_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      // in S_DONE the load below decides rsp_valid
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur       <= req;
            idx       <= '0;
            res_hit   <= 1'b0;
            res_entry <= '0;
            res_rate  <= '0;
            unique case (req.req_type) inside
              REQ_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              REQ_FIND_ID, REQ_FIND_DOM, REQ_RES_ID, REQ_RES_DOM: begin
                state <= S_SCAN_RD;
              end
              default: begin
                res_status <= ST_MISS;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN_RD: begin
          if (idx >= cnt) begin
            if (is_insert) begin
              pos   <= idx;
              idx   <= cnt;
              state <= S_SHIFT_RD;
            end else begin
              res_status <= ST_MISS;
              res_rate   <= is_resolve ? miss_rate : 32'd0;
              state      <= S_DONE;
            end
          end else begin
            state <= S_SCAN_CMP;
          end
        end

        S_SCAN_CMP: begin
          if (match) begin
            if (is_insert) begin
              res_status <= ST_DUP;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              res_hit    <= 1'b1;
              res_entry  <= rd_data;
              state      <= is_resolve ? S_GRANT_LIM : S_DONE;
            end
          end else if (past) begin
            // ids are sorted, so the key is absent and belongs here
            if (is_insert) begin
              pos   <= idx;
              idx   <= cnt;
              state <= S_SHIFT_RD;
            end else begin
              res_status <= ST_MISS;
              res_rate   <= is_resolve ? miss_rate : 32'd0;
              state      <= S_DONE;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SCAN_RD;
          end
        end

        S_SHIFT_RD: begin
          state <= (idx > pos) ? S_SHIFT_WR : S_INS_WR;
        end

        S_SHIFT_WR: begin
          idx   <= idx_m1;
          state <= S_SHIFT_RD;
        end

        S_INS_WR: begin
          cnt        <= cnt + CW'(1);
          res_status <= ST_OK;
          state      <= S_DONE;
        end

        S_GRANT_LIM: begin
          lo_r  <= lo_eff;
          hi_r  <= cur.interest_flag ? bnd(cap_eff, lo_eff, hi_eff) : hi_eff;
          state <= S_GRANT_OUT;
        end

        S_GRANT_OUT: begin
          res_rate <= bnd(req_eff, lo_r, hi_r);
          state    <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.status        <= res_status;
            rsp.hit           <= res_hit;
            rsp.found_policy  <= res_entry.id;
            rsp.found_domain  <= res_entry.domain;
            rsp.found_floor   <= res_entry.floor_val;
            rsp.found_ceiling <= res_entry.ceiling_val;
            rsp.found_cap     <= res_entry.cap_val;
            rsp.resolved_rate <= res_rate;
            rsp.entries_used  <= 5'(cnt);
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/spwr_checker.sv @@
// port-level checks for the warp resolver, bound to the resolver core
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spwr_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input spwr_pkg::rsp_t rsp
);
  import spwr_pkg::*;

  // a stalled response beat holds
  `CHK_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // a taken request keeps the block busy for the next cycle
  `CHK_NEXT(a_busy_after_req, clk, rst, req_valid && !req_stall, req_stall)

  // a miss carries no entry
  `CHK_NOW(a_miss_zero, clk, rst, rsp_valid && !rsp.hit,
    rsp.found_policy == 64'd0 && rsp.found_domain == 64'd0 && rsp.found_floor == 32'd0 &&
    rsp.found_ceiling == 32'd0 && rsp.found_cap == 32'd0)

  // a rejected insert reports neither a hit nor a rate
  `CHK_NOW(a_reject_clean, clk, rst, rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_DUP),
    !rsp.hit && rsp.resolved_rate == 32'd0)

endmodule

bind sorted_policy_table_warp_resolver_core spwr_checker u_spwr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
